### rtl/core/krdmc_pkg.sv
// ----------------------------------------------------------------------------
// krdmc_pkg
// Types and constants shared by the key release detector and mode control.
// ----------------------------------------------------------------------------
package krdmc_pkg;

   localparam int INPUT_KEYS  = 4;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [15:0] CNT_IDLE     = 16'hFFFF;
   localparam logic [15:0] CNT_SAT      = 16'hFFF0;
   localparam logic [15:0] THRESH_RESET = 16'd5;
   localparam logic [2:0]  BRUSH_MAX    = 3'd5;
   localparam logic [9:0]  DUTY_STEP    = 10'd200;
   localparam logic [2:0]  FAN_WRAP     = 3'd4;
   localparam logic [1:0]  DIR_FWD      = 2'd1;
   localparam logic [1:0]  DIR_BACK     = 2'd2;

   // Event codes (1 + key index)
   localparam logic [4:0] EV_BRUSH = 5'd1;
   localparam logic [4:0] EV_RUN   = 5'd3;
   localparam logic [4:0] EV_FAN   = 5'd4;

   typedef enum logic [2:0] {
      CMD_NONE,
      CMD_BRUSH,
      CMD_OTHER,
      CMD_RUN,
      CMD_FAN
   } cmd_type;

   typedef struct packed {
      logic       tick_valid;
      logic [3:0] key_levels;
   } req_type;

   typedef struct packed {
      logic [2:0] key_event;
      logic [2:0] brush_level;
      logic [9:0] brush_duty;
      logic       motor_power;
      logic [1:0] fan_rank;
      logic       run_state;
      logic [1:0] drive_direction;
      logic       stop_all;
      logic       activity;
   } rsp_type;

   typedef struct packed {
      cmd_type    cmd;
      logic [2:0] key_event;
   } evt_type;

   typedef struct packed {
      logic push;
      logic pop;
   } qctl_type;

endpackage

### rtl/core/krdmc_front.sv
// ----------------------------------------------------------------------------
// krdmc_front
// Per-key press counters and release scan; classifies each sample into a
// controller command.
// ----------------------------------------------------------------------------
module krdmc_front import krdmc_pkg::*; #(
   parameter int KEY_COUNT = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        take,
   input  req_type     req_data,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data,
   output evt_type     evt_out
);

   localparam int IDX_W = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;

   logic [15:0]          cnt_ff [KEY_COUNT];
   logic [15:0]          cnt_in [KEY_COUNT];
   logic [15:0]          thr_ff;
   logic [KEY_COUNT-1:0] pressed;
   logic [KEY_COUNT-1:0] hit;
   logic [KEY_COUNT-1:0] upd_en;
   logic [15:0]          cnt_upd [KEY_COUNT];
   logic                 seen;
   logic [IDX_W-1:0]     hit_idx;
   logic [4:0]           ev_code;

   for (genvar i = 0; i < KEY_COUNT; i++) begin : g_key
      if (i < INPUT_KEYS) begin : g_in
         assign pressed[i] = req_data.key_levels[i];
      end else begin : g_none
         assign pressed[i] = 1'b0;
      end

      assign hit[i] = !pressed[i] && (cnt_ff[i] < CNT_SAT) && (cnt_ff[i] > thr_ff);

      always_comb begin
         if (!pressed[i]) begin
            cnt_upd[i] = CNT_IDLE;
         end else if (cnt_ff[i] < CNT_SAT) begin
            cnt_upd[i] = cnt_ff[i] + 16'd1;
         end else if (cnt_ff[i] == CNT_IDLE) begin
            cnt_upd[i] = 16'd0;
         end else begin
            cnt_upd[i] = cnt_ff[i];
         end
      end

      assign cnt_in[i] = upd_en[i] ? cnt_upd[i] : cnt_ff[i];
   end

   // scan stops at the first qualifying release
   always_comb begin
      seen    = 1'b0;
      hit_idx = '0;
      upd_en  = '0;
      for (int i = 0; i < KEY_COUNT; i++) begin
         upd_en[i] = take && req_data.tick_valid && !seen;
         if (!seen && hit[i]) begin
            seen    = 1'b1;
            hit_idx = IDX_W'(i);
         end
      end
   end

   assign ev_code = 5'(hit_idx) + 5'd1;

   always_comb begin
      evt_out.key_event = 3'd0;
      evt_out.cmd       = CMD_NONE;
      if (req_data.tick_valid && seen) begin
         evt_out.key_event = ev_code[2:0];
         case (ev_code)
            EV_BRUSH: evt_out.cmd = CMD_BRUSH;
            EV_RUN:   evt_out.cmd = CMD_RUN;
            EV_FAN:   evt_out.cmd = CMD_FAN;
            default:  evt_out.cmd = CMD_OTHER;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THRESH_RESET;
         for (int i = 0; i < KEY_COUNT; i++) begin
            cnt_ff[i] <= CNT_IDLE;
         end
      end else begin
         if (csr_wr_en) begin
            thr_ff <= csr_wr_data;
         end
         for (int i = 0; i < KEY_COUNT; i++) begin
            cnt_ff[i] <= cnt_in[i];
         end
      end
   end

endmodule

### rtl/core/krdmc_queue.sv
// ----------------------------------------------------------------------------
// krdmc_queue
// Short event queue between the key scan and the mode controller.
// ----------------------------------------------------------------------------
module krdmc_queue import krdmc_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  qctl_type ctl_in,
   input  evt_type  wr_data,
   output evt_type  rd_data,
   output logic     full,
   output logic     empty
);

   evt_type           mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff;
   logic [QPTR_W-1:0] rd_ptr_ff;
   logic [QCNT_W-1:0] count_ff;
   logic [QCNT_W-1:0] count_in;

   assign full    = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign rd_data = mem_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (ctl_in.push && !ctl_in.pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (!ctl_in.push && ctl_in.pop) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (ctl_in.push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (ctl_in.push) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         end
         if (ctl_in.pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         end
         count_ff <= count_in;
      end
   end

endmodule

### rtl/core/krdmc_back.sv
// ----------------------------------------------------------------------------
// krdmc_back
// Mode controller: brush, fan and run state, with registered result.
// ----------------------------------------------------------------------------
module krdmc_back import krdmc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  evt_type evt_in,
   input  logic    evt_avail,
   output logic    evt_pop,
   input  logic    rsp_ready,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   logic [2:0] brush_ff, brush_in;
   logic [1:0] fan_ff, fan_in;
   logic       run_ff, run_in;
   logic [1:0] dir_ff, dir_in;
   logic       pwr_ff, pwr_in;
   logic       stop;
   logic [2:0] brush_inc;
   logic [2:0] fan_inc;
   logic       rsp_valid_ff;
   rsp_type    rsp_data_ff, rsp_data_in;

   assign evt_pop   = evt_avail && (!rsp_valid_ff || rsp_ready);
   assign brush_inc = brush_ff + 3'd1;
   assign fan_inc   = {1'b0, fan_ff} + 3'd1;

   always_comb begin
      brush_in = brush_ff;
      fan_in   = fan_ff;
      run_in   = run_ff;
      dir_in   = dir_ff;
      pwr_in   = pwr_ff;
      stop     = 1'b0;
      case (evt_in.cmd)
         CMD_BRUSH: begin
            if (brush_inc > BRUSH_MAX) begin
               brush_in = 3'd0;
               pwr_in   = 1'b0;
            end else begin
               brush_in = brush_inc;
               pwr_in   = 1'b1;
            end
         end
         CMD_RUN: begin
            if (!run_ff) begin
               pwr_in = 1'b1;
               dir_in = (dir_ff == DIR_FWD) ? DIR_BACK : DIR_FWD;
               run_in = 1'b1;
            end else begin
               run_in = 1'b0;
               stop   = 1'b1;
            end
         end
         CMD_FAN: begin
            fan_in = (fan_inc >= FAN_WRAP) ? 2'd0 : fan_inc[1:0];
            if (fan_in == 2'd1) begin
               pwr_in = 1'b1;
            end else if (fan_in == 2'd0) begin
               pwr_in = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_data_in.key_event       = evt_in.key_event;
      rsp_data_in.brush_level     = brush_in;
      rsp_data_in.brush_duty      = 10'({7'd0, brush_in} * DUTY_STEP);
      rsp_data_in.motor_power     = pwr_in;
      rsp_data_in.fan_rank        = fan_in;
      rsp_data_in.run_state       = run_in;
      rsp_data_in.drive_direction = dir_in;
      rsp_data_in.stop_all        = stop;
      rsp_data_in.activity        = (evt_in.cmd != CMD_NONE);
   end

   always_ff @(posedge clock) begin
      if (evt_pop) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         brush_ff     <= 3'd0;
         fan_ff       <= 2'd0;
         run_ff       <= 1'b0;
         dir_ff       <= 2'd0;
         pwr_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (evt_pop) begin
            brush_ff <= brush_in;
            fan_ff   <= fan_in;
            run_ff   <= run_in;
            dir_ff   <= dir_in;
            pwr_ff   <= pwr_in;
         end
         if (evt_pop) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

### rtl/core/key_release_detector_mode_control_core.sv
// Key release detector with mode control. One sample transaction is taken per
// clock and one result transaction leaves per clock when the consumer keeps up;
// each result is registered in the event queue, then in the response register.
// The per-key press counters update in the cycle a sample is accepted; a
// two-entry event queue separates the scan from the mode controller, so a result
// stall holds up the scan only once the queue is full. The user must write the
// threshold register with csr_wr_en while the block is idle; nothing enforces it.
// ----------------------------------------------------------------------------
// key_release_detector_mode_control_core
// Top level: key scan front end, event queue and mode controller.
// ----------------------------------------------------------------------------
module key_release_detector_mode_control_core import krdmc_pkg::*; #(
   parameter int KEY_COUNT = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);

   evt_type  evt_new;
   evt_type  evt_head;
   qctl_type qctl;
   logic     q_full;
   logic     q_empty;
   logic     take;
   logic     pop;

   assign req_ready = !q_full;
   assign take      = req_valid && req_ready;

   assign qctl.push = take;
   assign qctl.pop  = pop;

   krdmc_front #(
      .KEY_COUNT (KEY_COUNT)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .take        (take),
      .req_data    (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .evt_out     (evt_new)
   );

   krdmc_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .ctl_in  (qctl),
      .wr_data (evt_new),
      .rd_data (evt_head),
      .full    (q_full),
      .empty   (q_empty)
   );

   krdmc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .evt_in    (evt_head),
      .evt_avail (!q_empty),
      .evt_pop   (pop),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

`ifndef NO_ASSERTIONS
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      q_empty |-> !qctl.pop)
      else $error("event popped from empty queue");

   a_stop_clears_run: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.stop_all) |-> !rsp_data.run_state)
      else $error("stop pulse while still running");

   a_brush_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.brush_level <= BRUSH_MAX))
      else $error("brush level out of range");

   a_event_activity: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.key_event != 3'd0) |-> rsp_data.activity)
      else $error("key event without activity pulse");
`endif

endmodule

### dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the key release detector with mode control.
// Drives millisecond key samples through the request channel and checks
// every status transaction against a cycle-free predictor of the press
// counters and the brush, fan and drive controller. The threshold register
// is varied between phases. Idling on both channels is randomised.
// ----------------------------------------------------------------------------
module testbench import krdmc_pkg::*;;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 1_000_000;

   // Predicts the status transaction for each accepted sample and checks results
   class mode_ctrl_scoreboard;
      logic [15:0] counts [INPUT_KEYS];
      logic [15:0] threshold;
      logic [2:0]  brush;
      logic [1:0]  fan;
      logic        running;
      logic [1:0]  direction;
      logic        power;
      rsp_type     pending [$];
      int          errors;
      int          checked;
      int          events;
      int          stops;

      function void clear();
         foreach (counts[k]) counts[k] = CNT_IDLE;
         threshold = THRESH_RESET;
         brush     = '0;
         fan       = '0;
         running   = 1'b0;
         direction = '0;
         power     = 1'b0;
         pending.delete();
         errors    = 0;
         checked   = 0;
         events    = 0;
         stops     = 0;
      endfunction

      function void predict_status(req_type s);
         rsp_type     r;
         cmd_type     cmd;
         logic [15:0] c;
         logic [2:0]  f;
         cmd = CMD_NONE;
         r   = '0;
         if (s.tick_valid) begin
            for (int k = 0; k < INPUT_KEYS; k++) begin
               if (cmd == CMD_NONE) begin
                  c = counts[k];
                  if (s.key_levels[k]) begin
                     if (c < CNT_SAT) counts[k] = c + 16'd1;
                     else if (c == CNT_IDLE) counts[k] = '0;
                  end else begin
                     counts[k] = CNT_IDLE;
                     // scan stops at the first qualifying release
                     if (c < CNT_SAT && c > threshold) cmd = cmd_type'(k + 1);
                  end
               end
            end
         end
         case (cmd)
            CMD_BRUSH: begin
               brush = brush + 3'd1;
               if (brush > BRUSH_MAX) begin
                  brush = '0;
                  power = 1'b0;
               end else begin
                  power = 1'b1;
               end
            end
            CMD_RUN: begin
               if (!running) begin
                  power     = 1'b1;
                  direction = (direction == DIR_FWD) ? DIR_BACK : DIR_FWD;
                  running   = 1'b1;
               end else begin
                  running    = 1'b0;
                  r.stop_all = 1'b1;
               end
            end
            CMD_FAN: begin
               f = {1'b0, fan} + 3'd1;
               if (f >= FAN_WRAP) f = '0;
               fan = f[1:0];
               if (fan == 2'd1) power = 1'b1;
               else if (fan == 2'd0) power = 1'b0;
            end
            default: begin
            end
         endcase
         r.key_event       = cmd;
         r.brush_level     = brush;
         r.brush_duty      = {7'd0, brush} * DUTY_STEP;
         r.motor_power     = power;
         r.fan_rank        = fan;
         r.run_state       = running;
         r.drive_direction = direction;
         r.activity        = (cmd != CMD_NONE);
         pending.push_back(r);
      endfunction

      function void compare(string name, logic [15:0] want, logic [15:0] got);
         if (got !== want) begin
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            errors++;
         end
      endfunction

      function void check_status(rsp_type got);
         rsp_type want;
         if (pending.size() == 0) begin
            $display("%0t ns: status transaction with nothing outstanding, got %h", $time, got);
            errors++;
            return;
         end
         want = pending.pop_front();
         checked++;
         if (want.activity) events++;
         if (want.stop_all) stops++;
         compare("key_event", 16'(want.key_event), 16'(got.key_event));
         compare("brush_level", 16'(want.brush_level), 16'(got.brush_level));
         compare("brush_duty", 16'(want.brush_duty), 16'(got.brush_duty));
         compare("motor_power", 16'(want.motor_power), 16'(got.motor_power));
         compare("fan_rank", 16'(want.fan_rank), 16'(got.fan_rank));
         compare("run_state", 16'(want.run_state), 16'(got.run_state));
         compare("drive_direction", 16'(want.drive_direction), 16'(got.drive_direction));
         compare("stop_all", 16'(want.stop_all), 16'(got.stop_all));
         compare("activity", 16'(want.activity), 16'(got.activity));
      endfunction
   endclass

   logic        clock;
   logic        reset       = 1'b1;
   logic        req_valid   = 1'b0;
   logic        req_ready;
   req_type     req_data    = '0;
   logic        rsp_valid;
   logic        rsp_ready   = 1'b0;
   rsp_type     rsp_data;
   logic        csr_wr_en   = 1'b0;
   logic [15:0] csr_wr_data = '0;

   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;
   int          samples_sent  = 0;
   int          ticks_sent    = 0;
   int          cycles        = 0;

   mode_ctrl_scoreboard sb = new;

   key_release_detector_mode_control_core u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) sb.predict_status(req_data);
         if (rsp_valid && rsp_ready) sb.check_status(rsp_data);
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("%0t ns: timeout, %0d results outstanding", $time, sb.pending.size());
         $display("** key_release_detector_mode_control_core: FAILED **");
         $finish;
      end
   end

   // Called at a falling edge; returns at the falling edge after acceptance
   task automatic send_sample(input req_type s);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= s;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      samples_sent++;
      if (s.tick_valid) ticks_sent++;
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_threshold(input logic [15:0] value);
      drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      sb.threshold = value;
   endtask

   // Hold the keys in mask for n ticks, then release everything
   task automatic press(input logic [3:0] mask, input int n);
      repeat (n) send_sample('{tick_valid: 1'b1, key_levels: mask});
      send_sample('{tick_valid: 1'b1, key_levels: 4'b0000});
   endtask

   // Mostly well-formed press/release sequences, sized around the threshold when it is at most 64
   task automatic run_random(input int n_ticks, input logic [15:0] thr);
      int      sent;
      int      roll;
      int      hold [INPUT_KEYS];
      req_type s;
      write_threshold(thr);
      sent = 0;
      foreach (hold[k]) hold[k] = 0;
      while (sent < n_ticks) begin
         roll         = $urandom_range(99);
         s.tick_valid = (roll >= 8);
         s.key_levels = 4'($urandom);
         if (roll >= 14) begin
            for (int k = 0; k < INPUT_KEYS; k++) begin
               if (hold[k] > 0) begin
                  s.key_levels[k] = 1'b1;
                  hold[k]--;
               end else begin
                  s.key_levels[k] = 1'b0;
                  if ($urandom_range(3) == 0) begin
                     if (thr > 16'd64 || $urandom_range(3) == 0) hold[k] = $urandom_range(1, 4);
                     else hold[k] = int'(thr) + $urandom_range(0, 4);
                  end
               end
            end
         end
         send_sample(s);
         if (s.tick_valid) sent++;
      end
   endtask

   initial begin
      logic [15:0] thr_a [3];
      logic [15:0] thr_b [3];
      thr_a = '{16'd5, 16'd12, 16'd3};
      thr_b = '{16'd1, 16'd0, 16'd2};
      sb.clear();
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // directed: lowest threshold, one event per key, scan stop on a double release
      write_threshold(16'd0);
      send_sample('{tick_valid: 1'b0, key_levels: 4'b1111});
      press(4'b0001, 1);
      press(4'b0001, 2);
      press(4'b0010, 2);
      press(4'b0100, 2);
      press(4'b1000, 2);
      press(4'b0101, 2);
      send_sample('{tick_valid: 1'b1, key_levels: 4'b0000});
      press(4'b1111, 3);

      for (int r = 0; r < 3; r++) begin
         send_idle_pct = (r == 0) ? 30 : (r == 1) ? 74 : 0;
         recv_idle_pct = (r == 0) ? 74 : (r == 1) ? 30 : 0;
         run_random(230, thr_a[r]);
         run_random(230, thr_b[r]);
      end

      // highest threshold: no event can fire
      send_idle_pct = 20;
      recv_idle_pct = 20;
      run_random(100, 16'hFFEF);

      drain();
      repeat (20) @(negedge clock);
      $display("Covered %0d sample transactions (%0d ticks), %0d results checked,",
               samples_sent, ticks_sent, sb.checked);
      $display("%0d key events, %0d drive stops, thresholds from 0 up to 65519.",
               sb.events, sb.stops);
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("** key_release_detector_mode_control_core: PASSED **");
      end else begin
         $display("** key_release_detector_mode_control_core: FAILED **");
      end
      $finish;
   end

endmodule
